>>> hw/rtl/gbp_pkg.sv
// Shared types and constants for the gshare predictor with branch target buffer.
// Used by the top level and gbp_mod_unit; depends on nothing else.
`default_nettype none

package gbp_pkg;

    // Width of a word address (pc with its two byte-offset bits dropped).
    localparam int unsigned WORD_ADDR_W = 30;

    localparam logic KIND_PREDICT = 1'b0;
    localparam logic KIND_UPDATE  = 1'b1;

    localparam logic [31:0] PC_STEP = 32'd4;
    localparam logic [1:0]  CTR_MAX = 2'd3;
    localparam logic [1:0]  CTR_MIN = 2'd0;

    typedef struct packed {
        logic        kind;
        logic [31:0] pc;
        logic        outcome_taken;
        logic        entry_valid;
        logic        cond_branch;
        logic [31:0] target;
    } gbp_req_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        pred_taken;
        logic        btb_miss;
    } gbp_rsp_t;

    typedef struct packed {
        logic [31:0] tag;
        logic        valid;
        logic        conditional;
        logic [31:0] target;
    } gbp_btb_entry_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_LOOKUP
    } gbp_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/gshare_btb_branch_predictor.sv
// Top level of the gshare branch predictor with a direct-mapped branch target buffer.
// Depends on gbp_pkg, gbp_ram and gbp_mod_unit.
`default_nettype none

// The block takes one item at a time on the req channel and returns one result on the
// rsp channel for each predict item; an update item returns nothing. With power-of-two
// table sizes an item goes through these steps before the block takes the next one: the
// table indices are formed and registered, the target buffer and the counter memory
// (both synchronous RAMs with a registered read) are read, and then either the result
// register is loaded or the counter, the history and the target buffer entry are written
// back. A table size that is not a power of two forms its index in registered steps of
// a reciprocal multiply, a back-multiply and a correcting subtract, which lengthens the
// index step. The result register lets the block take the next item while a result
// still waits on rsp_stall; a predict item that finds a result still held by rsp_stall
// waits in its lookup state. After reset the block clears both memories, one entry of
// each per cycle, through as many entries as the larger table has (1024 with the default
// sizes); req_stall stays high during that pass.
module gshare_btb_branch_predictor
    import gbp_pkg::*;
#(
    parameter int unsigned HISTORY_BITS    = 8,
    parameter int unsigned COUNTER_ENTRIES = 256,
    parameter int unsigned BTB_ENTRIES     = 1024
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire gbp_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output gbp_rsp_t      rsp
);

    localparam int unsigned CTR_IDX_W = $clog2(COUNTER_ENTRIES);
    localparam int unsigned BTB_IDX_W = $clog2(BTB_ENTRIES);
    localparam int unsigned CLR_DEPTH = (BTB_ENTRIES > COUNTER_ENTRIES) ?
                                        BTB_ENTRIES : COUNTER_ENTRIES;
    localparam int unsigned CLR_W     = $clog2(CLR_DEPTH);
    localparam int unsigned ENTRY_W   = $bits(gbp_btb_entry_t);

    localparam logic [CLR_W-1:0] CLR_LAST    = CLR_W'(CLR_DEPTH - 1);
    localparam logic [CLR_W:0]   CLR_BTB_END = (CLR_W + 1)'(BTB_ENTRIES);
    localparam logic [CLR_W:0]   CLR_CTR_END = (CLR_W + 1)'(COUNTER_ENTRIES);

    gbp_state_t               state_reg, state_next;
    gbp_req_t                 item_reg, item_next;
    logic [HISTORY_BITS-1:0]  hist_reg, hist_next;
    logic [CLR_W-1:0]         clr_reg, clr_next;
    gbp_rsp_t                 rsp_reg, rsp_next;
    logic                     rsp_valid_reg, rsp_valid_next;

    logic                     idx_start;
    logic [WORD_ADDR_W-1:0]   btb_word;
    logic [WORD_ADDR_W-1:0]   ctr_word;
    logic                     btb_idx_done, ctr_idx_done;
    logic [BTB_IDX_W-1:0]     btb_idx;
    logic [CTR_IDX_W-1:0]     ctr_idx;

    logic                     mem_rd_en;
    logic [ENTRY_W-1:0]       btb_rd_raw;
    gbp_btb_entry_t           btb_rd;
    logic [1:0]               ctr_rd;

    logic                     btb_wr_en;
    logic [BTB_IDX_W-1:0]     btb_wr_addr;
    gbp_btb_entry_t           btb_wr_data;
    logic                     ctr_wr_en;
    logic [CTR_IDX_W-1:0]     ctr_wr_addr;
    logic [1:0]               ctr_wr_data;

    logic                     hit;
    logic                     take;
    logic                     rsp_free;

    // Both indices come from the item captured at the transfer. The history cannot
    // change before the item's own last cycle, so the counter index uses the history
    // as it stood before an update shifts it.
    assign btb_word = req.pc[31:2];
    assign ctr_word = req.pc[31:2] ^ {{(WORD_ADDR_W - HISTORY_BITS){1'b0}}, hist_reg};

    gbp_mod_unit #(
        .MODULUS (BTB_ENTRIES)
    ) u_btb_idx (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (idx_start),
        .value     (btb_word),
        .done      (btb_idx_done),
        .remainder (btb_idx)
    );

    gbp_mod_unit #(
        .MODULUS (COUNTER_ENTRIES)
    ) u_ctr_idx (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (idx_start),
        .value     (ctr_word),
        .done      (ctr_idx_done),
        .remainder (ctr_idx)
    );

    gbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BTB_ENTRIES)
    ) u_btb_ram (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (btb_idx),
        .rd_data (btb_rd_raw),
        .wr_en   (btb_wr_en),
        .wr_addr (btb_wr_addr),
        .wr_data (btb_wr_data)
    );

    gbp_ram #(
        .WIDTH (2),
        .DEPTH (COUNTER_ENTRIES)
    ) u_ctr_ram (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (ctr_idx),
        .rd_data (ctr_rd),
        .wr_en   (ctr_wr_en),
        .wr_addr (ctr_wr_addr),
        .wr_data (ctr_wr_data)
    );

    assign btb_rd = gbp_btb_entry_t'(btb_rd_raw);

    // A hit needs the full stored tag to match the pc and the entry to be valid.
    // Unconditional branches are always taken; conditional ones when the counter
    // sits in one of its two upper states.
    assign hit      = btb_rd.valid && (btb_rd.tag == item_reg.pc);
    assign take     = hit && (!btb_rd.conditional || ctr_rd[1]);
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        hist_next      = hist_reg;
        clr_next       = clr_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        req_stall      = 1'b1;
        idx_start      = 1'b0;
        mem_rd_en      = 1'b0;
        btb_wr_en      = 1'b0;
        btb_wr_addr    = btb_idx;
        btb_wr_data    = '0;
        ctr_wr_en      = 1'b0;
        ctr_wr_addr    = ctr_idx;
        ctr_wr_data    = ctr_rd;

        // The waiting result leaves on its transfer unless a new one replaces it.
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Zero one entry of each memory per cycle.
                btb_wr_en   = ({1'b0, clr_reg} < CLR_BTB_END);
                btb_wr_addr = clr_reg[BTB_IDX_W-1:0];
                ctr_wr_en   = ({1'b0, clr_reg} < CLR_CTR_END);
                ctr_wr_addr = clr_reg[CTR_IDX_W-1:0];
                ctr_wr_data = CTR_MIN;
                clr_next    = clr_reg + CLR_W'(1);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    item_next  = req;
                    idx_start  = 1'b1;
                    state_next = ST_INDEX;
                end
            end

            ST_INDEX:
            begin
                if (btb_idx_done && ctr_idx_done)
                begin
                    mem_rd_en  = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end

            ST_LOOKUP:
            begin
                if (item_reg.kind == KIND_PREDICT)
                begin
                    if (rsp_free)
                    begin
                        rsp_next.next_pc    = take ? btb_rd.target
                                                   : item_reg.pc + PC_STEP;
                        rsp_next.pred_taken = take;
                        rsp_next.btb_miss   = !hit;
                        rsp_valid_next      = 1'b1;
                        state_next          = ST_IDLE;
                    end
                end
                else
                begin
                    // A resolved branch: train the counter and history only for a
                    // conditional branch, and always rewrite the target buffer entry.
                    if (item_reg.cond_branch)
                    begin
                        ctr_wr_en = 1'b1;
                        if (item_reg.outcome_taken)
                        begin
                            ctr_wr_data = (ctr_rd == CTR_MAX) ? ctr_rd : ctr_rd + 2'd1;
                        end
                        else
                        begin
                            ctr_wr_data = (ctr_rd == CTR_MIN) ? ctr_rd : ctr_rd - 2'd1;
                        end
                        hist_next = {hist_reg[HISTORY_BITS-2:0], item_reg.outcome_taken};
                    end
                    btb_wr_en               = 1'b1;
                    btb_wr_data.tag         = item_reg.pc;
                    btb_wr_data.valid       = item_reg.entry_valid;
                    btb_wr_data.conditional = item_reg.cond_branch;
                    btb_wr_data.target      = item_reg.target;
                    state_next              = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            hist_reg      <= '0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hist_reg      <= hist_next;
            clr_reg       <= clr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

>>> hw/rtl/gbp_ram.sv
// Single-port-write, single-port-read synchronous RAM with a registered read.
// Depends on no package; used for the branch target buffer and the pattern counters.
`default_nettype none

module gbp_ram #(
    parameter int unsigned WIDTH  = 2,
    parameter int unsigned DEPTH  = 256,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/gbp_mod_unit.sv
// Reduces a word address modulo a table size to form a table index.
// Uses gbp_pkg for the word-address width; a power-of-two size registers the low bits,
// any other size adds registered steps in turn: a reciprocal multiply, a back-multiply and a correction.
`default_nettype none

module gbp_mod_unit
    import gbp_pkg::*;
#(
    parameter int unsigned MODULUS = 256,
    parameter int unsigned IDX_W   = $clog2(MODULUS)
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [WORD_ADDR_W-1:0] value,
    output logic                        done,
    output logic      [IDX_W-1:0]       remainder
);

    generate
        if ((MODULUS & (MODULUS - 1)) == 0)
        begin : g_mask
            logic             done_reg;
            logic [IDX_W-1:0] rem_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else if (start)
                begin
                    done_reg <= 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg <= value[IDX_W-1:0];
                end
            end

            assign done      = done_reg;
            assign remainder = rem_reg;
        end
        else
        begin : g_recip
            localparam int unsigned PROD_W = 2 * WORD_ADDR_W;
            // Scaled reciprocal of the modulus. The quotient it gives is never high and at
            // most one short, so a single compare and subtract finishes the remainder.
            localparam logic [PROD_W-1:0] RECIP =
                PROD_W'((64'd1 << WORD_ADDR_W) / 64'(MODULUS));
            localparam logic [WORD_ADDR_W-1:0] MOD_V = WORD_ADDR_W'(MODULUS);
            localparam logic [1:0] STEPS = 2'd3;

            logic [1:0]             cnt_reg, cnt_next;
            logic                   done_reg, done_next;
            logic [WORD_ADDR_W-1:0] val_reg, val_next;
            logic [PROD_W-1:0]      prod_reg, prod_next;
            logic [WORD_ADDR_W-1:0] qm_reg, qm_next;
            logic [IDX_W-1:0]       rem_reg, rem_next;
            logic [WORD_ADDR_W-1:0] quot;
            logic [WORD_ADDR_W-1:0] diff;

            always_comb
            begin
                quot      = prod_reg[PROD_W-1:WORD_ADDR_W];
                diff      = val_reg - qm_reg;
                cnt_next  = cnt_reg;
                done_next = done_reg;
                val_next  = val_reg;
                prod_next = prod_reg;
                qm_next   = qm_reg;
                rem_next  = rem_reg;
                if (start)
                begin
                    cnt_next  = STEPS;
                    done_next = 1'b0;
                    val_next  = value;
                end
                else
                begin
                    unique case (cnt_reg)
                        2'd3:
                        begin
                            prod_next = PROD_W'(val_reg) * RECIP;
                            cnt_next  = 2'd2;
                        end
                        2'd2:
                        begin
                            // The product never exceeds the value, so it fits the word.
                            qm_next  = quot * MOD_V;
                            cnt_next = 2'd1;
                        end
                        2'd1:
                        begin
                            if (diff >= MOD_V)
                            begin
                                rem_next = IDX_W'(diff - MOD_V);
                            end
                            else
                            begin
                                rem_next = IDX_W'(diff);
                            end
                            done_next = 1'b1;
                            cnt_next  = 2'd0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cnt_reg  <= '0;
                    done_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg  <= cnt_next;
                    done_reg <= done_next;
                end
            end

            always_ff @(posedge clk)
            begin
                val_reg  <= val_next;
                prod_reg <= prod_next;
                qm_reg   <= qm_next;
                rem_reg  <= rem_next;
            end

            assign done      = done_reg;
            assign remainder = rem_reg;
        end
    endgenerate

endmodule

`default_nettype wire
